@@ hw/rtl/sxl_pkg.sv @@
package sxl_pkg;

   // Configuration register indexes.
   localparam logic CSR_IDX_PEN_COLOR  = 1'b0;
   localparam logic CSR_IDX_LINE_STYLE = 1'b1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int PEN_W      = 8;
   localparam int STYLE_W    = 3;
   localparam int PATTERN_W  = 16;

   localparam logic [PEN_W-1:0] PEN_RESET = 8'h01;

   // Style reload request from the register file to the pixel engine.
   typedef struct packed {
      logic                 load;
      logic [PATTERN_W-1:0] pattern;
   } style_load_type;

   // Fill state of the item queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Eight fixed dash patterns selected by the line style register.
   function automatic logic [PATTERN_W-1:0] dash_pattern(input logic [STYLE_W-1:0] sel);
      logic [PATTERN_W-1:0] pat;
      case (sel)
         3'd0:    pat = 16'hffff;
         3'd1:    pat = 16'h7777;
         3'd2:    pat = 16'h1863;
         3'd3:    pat = 16'h0303;
         3'd4:    pat = 16'h0770;
         3'd5:    pat = 16'h3333;
         3'd6:    pat = 16'h7077;
         3'd7:    pat = 16'h0630;
         default: pat = 16'hffff;
      endcase
      return pat;
   endfunction

endpackage

@@ hw/rtl/sxl_ifs.sv @@
interface sxl_req_if #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, op, start_x, start_y, end_x, end_y, pixel_in,
                   input ready);
   modport sink   (input valid, op, start_x, start_y, end_x, end_y, pixel_in,
                   output ready);
endinterface

interface sxl_rsp_if #(
   parameter int PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_out;
   logic                  last_pixel;

   modport source (output valid, pixel_out, last_pixel, input ready);
   modport sink   (input valid, pixel_out, last_pixel, output ready);
endinterface

@@ hw/rtl/styled_xor_line_pixels.sv @@
// Dashed-line XOR styling of a line segment. A start item (op 0) carries the
// two endpoints; it sets up the Bresenham error terms and a pixel count equal
// to the larger of the absolute x and y deltas, and returns no result. Each
// pixel item (op 1) then returns that pixel, XORed with pen_color when the top
// bit of the 16-bit dash pattern is set, with last_pixel marking the final
// pixel of the segment. Pixel items that arrive when no pixels are left are
// dropped without a result. A new start item abandons any pixels still left
// but keeps the dash phase. Writing line_style reloads the dash pattern from
// an eight-entry table and restarts the dash distance counter. The user must
// write pen_color and line_style only while the block is idle; the block
// itself does not enforce this. Throughput is one item per clock, start items
// included, as long as results are taken. An input register, a four-entry item
// queue and the pixel engine's output register sit in line, and a pixel's
// result passes through them in that order. The pixel engine updates the error
// term and the dash counter as it pops each item, which sets that pace.
module styled_xor_line_pixels #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   sxl_req_if.sink                        req_bus,
   sxl_rsp_if.source                      rsp_bus,
   input  logic                           csr_we,
   input  logic [sxl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sxl_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int QUEUE_W     = 2 * COORD_BITS + PIXEL_BITS + 1;
   localparam int QUEUE_DEPTH = 4;

   logic                         q_push, q_pop;
   logic [QUEUE_W-1:0]           q_in_data, q_head_data;
   sxl_pkg::queue_status_type    q_status;
   sxl_pkg::style_load_type      style_load;
   logic [sxl_pkg::PEN_W-1:0]    pen_color_ff;

   // The pen color is held here; a line style write is passed on to the
   // pixel engine as a one-cycle pattern reload.
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_color_ff <= sxl_pkg::PEN_RESET;
      end else if (csr_we && (csr_index == sxl_pkg::CSR_IDX_PEN_COLOR)) begin
         pen_color_ff <= csr_data[sxl_pkg::PEN_W-1:0];
      end
   end

   assign style_load.load    = csr_we && (csr_index == sxl_pkg::CSR_IDX_LINE_STYLE);
   assign style_load.pattern = sxl_pkg::dash_pattern(csr_data[sxl_pkg::STYLE_W-1:0]);

   // The input stage turns endpoints into absolute deltas.
   sxl_front #(
      .COORD_BITS (COORD_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_status.full),
      .q_push  (q_push),
      .q_data  (q_in_data)
   );

   // The queue lets the input side keep accepting while a result waits.
   sxl_queue #(
      .WIDTH (QUEUE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head_data (q_head_data),
      .status    (q_status)
   );

   // The pixel engine walks the line and styles each pixel.
   sxl_back #(
      .COORD_BITS (COORD_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_head_data),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .pen_color  (pen_color_ff),
      .style_load (style_load),
      .rsp_bus    (rsp_bus)
   );

   // The queue can never report full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("item queue reports full and empty together");

   // The input stage only pushes into a queue that has room.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into a full item queue");

   // A new result appears only after the pixel engine took an item.
   a_result_from_queue: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !$past(rsp_bus.valid)) |-> $past(q_pop))
      else $error("result without a dequeued item");

   // The engine never pops an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from an empty item queue");

endmodule

@@ hw/rtl/sxl_front.sv @@
// Input stage: registers each item and reduces segment endpoints to the
// absolute x and y deltas before the item enters the queue.
module sxl_front #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   sxl_req_if.sink                           req_bus,
   input  logic                              q_full,
   output logic                              q_push,
   output logic [2*COORD_BITS+PIXEL_BITS:0]  q_data
);

   logic                  vld_ff;
   logic                  op_ff;
   logic [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [COORD_BITS-1:0] dx, dy;
   logic                  take;

   assign req_bus.ready = !vld_ff || !q_full;
   assign take          = req_bus.valid && req_bus.ready;
   assign q_push        = vld_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (take) begin
         vld_ff <= 1'b1;
      end else if (q_push) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff  <= req_bus.op;
         x0_ff  <= req_bus.start_x;
         y0_ff  <= req_bus.start_y;
         x1_ff  <= req_bus.end_x;
         y1_ff  <= req_bus.end_y;
         pix_ff <= req_bus.pixel_in;
      end
   end

   assign dx = (x0_ff > x1_ff) ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
   assign dy = (y0_ff > y1_ff) ? (y0_ff - y1_ff) : (y1_ff - y0_ff);

   assign q_data = {op_ff, dx, dy, pix_ff};

endmodule

@@ hw/rtl/sxl_queue.sv @@
// Small register FIFO between the input stage and the pixel engine.
module sxl_queue #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          head_data,
   output sxl_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sxl_back.sv @@
// Pixel engine: loads the line setup from start items and styles one pixel
// item per cycle into the output register while results are taken.
module sxl_back #(
   parameter int COORD_BITS = 12,
   parameter int PIXEL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [2*COORD_BITS+PIXEL_BITS:0]  q_data,
   input  sxl_pkg::queue_status_type         q_status,
   output logic                              q_pop,
   input  logic [sxl_pkg::PEN_W-1:0]         pen_color,
   input  sxl_pkg::style_load_type           style_load,
   sxl_rsp_if.source                         rsp_bus
);

   localparam int ERR_W = COORD_BITS + 3;

   logic                          h_op;
   logic [COORD_BITS-1:0]         h_dx, h_dy;
   logic [PIXEL_BITS-1:0]         h_pix;
   logic [PIXEL_BITS-1:0]         pen_ext;

   logic [sxl_pkg::PATTERN_W-1:0] pattern_ff;
   logic [2:0]                    dist_ff;
   logic [ERR_W-1:0]              err_ff, axial_ff, diag_ff;
   logic [COORD_BITS-1:0]         left_ff;
   logic                          out_vld_ff;
   logic [PIXEL_BITS-1:0]         out_pix_ff;
   logic                          out_last_ff;

   logic [COORD_BITS-1:0]         major, minor;
   logic [ERR_W-1:0]              twice_minor, major_ext, twice_major;
   logic                          is_start, is_pixel, axial_step, styled;
   logic [2:0]                    dist_mid;

   assign {h_op, h_dx, h_dy, h_pix} = q_data;

   if (PIXEL_BITS <= sxl_pkg::PEN_W) begin : g_pen_narrow
      assign pen_ext = pen_color[PIXEL_BITS-1:0];
   end else begin : g_pen_wide
      assign pen_ext = {{(PIXEL_BITS - sxl_pkg::PEN_W){1'b0}}, pen_color};
   end

   assign q_pop    = !q_status.empty && (!out_vld_ff || rsp_bus.ready);
   assign is_start = q_pop && !h_op;
   assign is_pixel = q_pop && h_op && (left_ff != '0);

   // Equal deltas take the y-major branch.
   assign major       = (h_dx > h_dy) ? h_dx : h_dy;
   assign minor       = (h_dx > h_dy) ? h_dy : h_dx;
   assign twice_minor = {2'b00, minor, 1'b0};
   assign major_ext   = {3'b000, major};
   assign twice_major = {2'b00, major, 1'b0};

   assign axial_step = err_ff[ERR_W-1];
   assign styled     = pattern_ff[sxl_pkg::PATTERN_W-1];
   assign dist_mid   = dist_ff[2] ? (dist_ff + 3'd4) : dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= sxl_pkg::dash_pattern('0);
         dist_ff    <= '0;
         err_ff     <= '0;
         left_ff    <= '0;
      end else if (style_load.load) begin
         pattern_ff <= style_load.pattern;
         dist_ff    <= '0;
      end else if (is_start) begin
         err_ff  <= twice_minor - major_ext;
         left_ff <= major;
      end else if (is_pixel) begin
         if (dist_ff[2]) begin
            pattern_ff <= {pattern_ff[sxl_pkg::PATTERN_W-2:0], styled};
         end
         dist_ff <= dist_mid - (axial_step ? 3'd2 : 3'd3);
         err_ff  <= err_ff + (axial_step ? axial_ff : diag_ff);
         left_ff <= left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (is_start) begin
         axial_ff <= twice_minor;
         diag_ff  <= twice_minor - twice_major;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (is_pixel) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (is_pixel) begin
         out_pix_ff  <= styled ? (h_pix ^ pen_ext) : h_pix;
         out_last_ff <= (left_ff == COORD_BITS'(1));
      end
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.pixel_out  = out_pix_ff;
   assign rsp_bus.last_pixel = out_last_ff;

endmodule
